// ----- rtl/core/first_fit_block_allocator_core_assert.svh -----
// assertion macros shared by the checker
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, off while in reset
`define FFBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define FFBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ffba_pkg.sv -----
package ffba_pkg;

  // default geometry
  localparam int DEF_POOL_UNITS    = 1024;
  localparam int DEF_GRANULE_BYTES = 8;

  // field widths
  localparam int OP_W      = 2;
  localparam int BYTES_W   = 14;
  localparam int OFFSET_W  = 10;
  localparam int STATUS_W  = 2;
  localparam int LARGEST_W = 11;
  localparam int CFG_W     = 11;
  localparam int NEED_W    = BYTES_W + 1;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPACT = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

  // header store write kinds
  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_MERGE,
    WR_TAIL,
    WR_TAKE
  } wr_kind_t;

  // header store read address select
  typedef enum logic [1:0] {
    RD_NONE,
    RD_POS,
    RD_NXT
  } rd_kind_t;

  // result kinds
  typedef enum logic [2:0] {
    RES_OK,
    RES_ALLOC_OK,
    RES_NOFIT,
    RES_BADFREE,
    RES_COMPACT
  } res_kind_t;

  // controller to datapath
  typedef struct packed {
    logic      cfg_load;
    logic      capture;
    logic      need_mul;
    logic      need_fix;
    logic      merging;
    logic      latch_cur;
    rd_kind_t  rd;
    wr_kind_t  wr;
    logic      advance;
    logic      best;
    logic      res_load;
    res_kind_t res;
    logic      out_load;
  } ffba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            hdr_free;
    logic            fits;
    logic            nxt_in;
    logic            eff_zero;
    logic            pos_eq_tgt;
    logic            pos_lt_tgt;
    logic            cur_gt_need;
  } ffba_flags_t;

endpackage

// ----- rtl/core/ffba_datapath.sv -----
module ffba_datapath #(
  parameter int POOL_UNITS    = ffba_pkg::DEF_POOL_UNITS,
  parameter int GRANULE_BYTES = ffba_pkg::DEF_GRANULE_BYTES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ffba_pkg::ffba_cmd_t                cmd,
  input  logic [ffba_pkg::OP_W-1:0]          in_op,
  input  logic [ffba_pkg::BYTES_W-1:0]       in_bytes,
  input  logic [ffba_pkg::OFFSET_W-1:0]      in_offset,
  input  logic [ffba_pkg::CFG_W-1:0]         cfg_value,
  output ffba_pkg::ffba_flags_t              flags,
  output logic [ffba_pkg::STATUS_W-1:0]      out_status,
  output logic [ffba_pkg::OFFSET_W-1:0]      out_offset,
  output logic [ffba_pkg::LARGEST_W-1:0]     out_largest
);

  localparam int AW    = $clog2(POOL_UNITS);
  localparam int SW    = $clog2(POOL_UNITS + 1);
  localparam int EW    = SW + 1;
  localparam int NW    = ffba_pkg::NEED_W;
  localparam int CW    = (NW > SW) ? NW : SW;
  localparam int TW    = (SW > ffba_pkg::OFFSET_W) ? SW : ffba_pkg::OFFSET_W;
  localparam int XW    = ffba_pkg::BYTES_W + 1;
  localparam int OW    = ffba_pkg::OFFSET_W;
  localparam int LW    = ffba_pkg::LARGEST_W;
  localparam int SHIFT = 16;
  localparam int MW    = SHIFT + 1;
  localparam int PW    = XW + MW;
  localparam logic [MW-1:0] MULT = MW'((1 << SHIFT) / GRANULE_BYTES);

  // header store: flag in the top bit, size below
  logic [EW-1:0] mem [POOL_UNITS];
  logic [EW-1:0] rdata_r;

  logic [ffba_pkg::OP_W-1:0]      op_r;
  logic [XW-1:0]                  x_r;
  logic [ffba_pkg::OFFSET_W-1:0]  tgt_r;
  logic [PW-1:0]                  prod_r;
  logic [NW-1:0]                  need_r;
  logic [SW-1:0]                  pos_r;
  logic [SW-1:0]                  cur_r;
  logic [SW-1:0]                  best_r;
  logic [SW-1:0]                  pool_r;
  logic [ffba_pkg::STATUS_W-1:0]  res_status_r;
  logic [ffba_pkg::OFFSET_W-1:0]  res_off_r;
  logic [ffba_pkg::LARGEST_W-1:0] res_large_r;
  logic [ffba_pkg::STATUS_W-1:0]  res_status_nxt;
  logic [ffba_pkg::OFFSET_W-1:0]  res_off_nxt;
  logic [ffba_pkg::LARGEST_W-1:0] res_large_nxt;
  logic [ffba_pkg::STATUS_W-1:0]  out_status_r;
  logic [ffba_pkg::OFFSET_W-1:0]  out_off_r;
  logic [ffba_pkg::LARGEST_W-1:0] out_large_r;

  logic [SW-1:0] hdr_size;
  logic          hdr_free;
  logic [SW-1:0] eff;
  logic [SW:0]   nxt_sum;
  logic [SW-1:0] best_upd;
  logic [XW-1:0] q0;
  logic [XW-1:0] rem;
  logic [NW-1:0] need_nxt;
  logic [31:0]   cfg_v32;
  logic [SW-1:0] pool_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  // header fields and the size in hand
  assign hdr_size = rdata_r[SW-1:0];
  assign hdr_free = !rdata_r[EW-1];

  always_comb begin
    if (cmd.merging) begin
      if (hdr_free) begin
        eff = SW'({1'b0, cur_r} + {1'b0, hdr_size});
      end else begin
        eff = cur_r;
      end
    end else begin
      eff = hdr_size;
    end
  end

  assign nxt_sum  = {1'b0, pos_r} + {1'b0, eff};
  assign best_upd = (cmd.best && (eff > best_r)) ? eff : best_r;

  // status back to the controller
  assign flags.op          = op_r;
  assign flags.hdr_free    = hdr_free;
  assign flags.fits        = CW'(eff) >= CW'(need_r);
  assign flags.nxt_in      = nxt_sum < {1'b0, pool_r};
  assign flags.eff_zero    = (eff == '0);
  assign flags.pos_eq_tgt  = TW'(pos_r) == TW'(tgt_r);
  assign flags.pos_lt_tgt  = TW'(pos_r) < TW'(tgt_r);
  assign flags.cur_gt_need = CW'(cur_r) > CW'(need_r);

  // granule count: reciprocal product, then one correction step
  assign q0       = prod_r[SHIFT +: XW];
  assign rem      = x_r - XW'(q0 * GRANULE_BYTES);
  assign need_nxt = NW'(q0) + NW'(1) + NW'(rem >= XW'(GRANULE_BYTES));

  // pool size clamp
  assign cfg_v32 = 32'(cfg_value);
  always_comb begin
    if (cfg_v32 < 32'd2) begin
      pool_nxt = SW'(2);
    end else if (cfg_v32 > 32'(POOL_UNITS)) begin
      pool_nxt = SW'(POOL_UNITS);
    end else begin
      pool_nxt = SW'(cfg_v32);
    end
  end

  // write port select
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = pos_r[AW-1:0];
    wr_data = {1'b0, eff};
    case (cmd.wr)
      ffba_pkg::WR_INIT: begin
        wr_addr = '0;
        wr_data = {1'b0, pool_r};
      end
      ffba_pkg::WR_MERGE: begin
        wr_data = {1'b0, eff};
      end
      ffba_pkg::WR_TAIL: begin
        wr_addr = AW'(pos_r + SW'(need_r));
        wr_data = {1'b0, SW'(cur_r - SW'(need_r))};
      end
      ffba_pkg::WR_TAKE: begin
        wr_data = {1'b1, SW'(need_r)};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // read port select
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = pos_r[AW-1:0];
    case (cmd.rd)
      ffba_pkg::RD_POS: rd_addr = pos_r[AW-1:0];
      ffba_pkg::RD_NXT: rd_addr = nxt_sum[AW-1:0];
      default:          rd_en   = 1'b0;
    endcase
  end

  // header store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // pool size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= SW'(POOL_UNITS);
    end else if (cmd.cfg_load) begin
      pool_r <= pool_nxt;
    end
  end

  // request and walk registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      x_r    <= XW'(in_bytes) + XW'(GRANULE_BYTES - 1);
      tgt_r  <= in_offset;
      pos_r  <= '0;
      best_r <= '0;
    end else begin
      if (cmd.advance) begin
        pos_r <= nxt_sum[SW-1:0];
      end
      if (cmd.best) begin
        best_r <= best_upd;
      end
    end
    if (cmd.need_mul) begin
      prod_r <= PW'(x_r) * PW'(MULT);
    end
    if (cmd.need_fix) begin
      need_r <= need_nxt;
    end
    if (cmd.latch_cur) begin
      cur_r <= eff;
    end
  end

  // result fields for the finished request
  always_comb begin
    res_status_nxt = ffba_pkg::ST_OK;
    res_off_nxt    = '0;
    res_large_nxt  = '0;
    case (cmd.res)
      ffba_pkg::RES_ALLOC_OK: res_off_nxt    = OW'(pos_r);
      ffba_pkg::RES_NOFIT:    res_status_nxt = ffba_pkg::ST_NOFIT;
      ffba_pkg::RES_BADFREE:  res_status_nxt = ffba_pkg::ST_BADFREE;
      ffba_pkg::RES_COMPACT:  res_large_nxt  = LW'(best_upd);
      default:                res_status_nxt = ffba_pkg::ST_OK;
    endcase
  end

  // result and output registers
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status_r <= res_status_nxt;
      res_off_r    <= res_off_nxt;
      res_large_r  <= res_large_nxt;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_off_r    <= res_off_r;
      out_large_r  <= res_large_r;
    end
  end

  assign out_status  = out_status_r;
  assign out_offset  = out_off_r;
  assign out_largest = out_large_r;

endmodule

// ----- rtl/core/ffba_ctrl.sv -----
module ffba_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  ffba_pkg::ffba_flags_t flags,
  output ffba_pkg::ffba_cmd_t   cmd
);

  typedef enum logic [12:0] {
    S_INIT  = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_NEED1 = 13'b0000000000100,
    S_NEED2 = 13'b0000000001000,
    S_START = 13'b0000000010000,
    S_HDR   = 13'b0000000100000,
    S_NXT   = 13'b0000001000000,
    S_FCHK  = 13'b0000010000000,
    S_FHDR  = 13'b0000100000000,
    S_FNXT  = 13'b0001000000000,
    S_TAKE  = 13'b0010000000000,
    S_TAKE2 = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   is_alloc, is_free, is_compact;

  assign is_alloc   = (flags.op == ffba_pkg::OP_ALLOC);
  assign is_free    = (flags.op == ffba_pkg::OP_FREE);
  assign is_compact = (flags.op == ffba_pkg::OP_COMPACT);

  assign cfg_ready  = (state_r == S_IDLE);
  assign in_tready  = (state_r == S_IDLE) && !cfg_valid;
  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        cmd.wr    = ffba_pkg::WR_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.cfg_load = 1'b1;
          state_nxt    = S_INIT;
        end else if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_NEED1;
        end
      end
      S_NEED1: begin
        cmd.need_mul = 1'b1;
        state_nxt    = S_NEED2;
      end
      S_NEED2: begin
        cmd.need_fix = 1'b1;
        if (is_alloc || is_compact) begin
          state_nxt = S_START;
        end else if (is_free) begin
          state_nxt = S_FCHK;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res      = ffba_pkg::RES_OK;
          state_nxt    = S_DONE;
        end
      end
      S_START: begin
        cmd.rd    = ffba_pkg::RD_POS;
        state_nxt = S_HDR;
      end
      // header of the block at pos is in hand
      S_HDR: begin
        if (is_free) begin
          if (flags.eff_zero || !flags.nxt_in) begin
            cmd.res_load = 1'b1;
            cmd.res      = ffba_pkg::RES_BADFREE;
            state_nxt    = S_DONE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_FCHK;
          end
        end else if (flags.hdr_free) begin
          cmd.latch_cur = 1'b1;
          if (is_alloc && flags.fits) begin
            state_nxt = S_TAKE;
          end else if (flags.nxt_in) begin
            cmd.rd    = ffba_pkg::RD_NXT;
            state_nxt = S_NXT;
          end else begin
            cmd.best     = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res      = is_alloc ? ffba_pkg::RES_NOFIT : ffba_pkg::RES_COMPACT;
            state_nxt    = S_DONE;
          end
        end else if (flags.eff_zero || !flags.nxt_in) begin
          cmd.res_load = 1'b1;
          cmd.res      = is_alloc ? ffba_pkg::RES_NOFIT : ffba_pkg::RES_COMPACT;
          state_nxt    = S_DONE;
        end else begin
          // skip an allocated block and fetch the one after it
          cmd.advance = 1'b1;
          cmd.rd      = ffba_pkg::RD_NXT;
          state_nxt   = S_HDR;
        end
      end
      // header of the neighbor after the free block at pos is in hand
      S_NXT: begin
        cmd.merging = 1'b1;
        if (flags.hdr_free) begin
          cmd.wr        = ffba_pkg::WR_MERGE;
          cmd.latch_cur = 1'b1;
          if (is_alloc && flags.fits) begin
            state_nxt = S_TAKE;
          end else if (flags.nxt_in) begin
            cmd.rd    = ffba_pkg::RD_NXT;
            state_nxt = S_NXT;
          end else begin
            cmd.best     = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res      = is_alloc ? ffba_pkg::RES_NOFIT : ffba_pkg::RES_COMPACT;
            state_nxt    = S_DONE;
          end
        end else begin
          // neighbor allocated: move on to it
          cmd.best    = 1'b1;
          cmd.advance = 1'b1;
          cmd.rd      = ffba_pkg::RD_NXT;
          state_nxt   = S_HDR;
        end
      end
      // free walk: compare pos with the target
      S_FCHK: begin
        if (flags.pos_eq_tgt) begin
          cmd.rd    = ffba_pkg::RD_POS;
          state_nxt = S_FHDR;
        end else if (flags.pos_lt_tgt) begin
          cmd.rd    = ffba_pkg::RD_POS;
          state_nxt = S_HDR;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res      = ffba_pkg::RES_BADFREE;
          state_nxt    = S_DONE;
        end
      end
      S_FHDR: begin
        if (flags.hdr_free) begin
          cmd.res_load = 1'b1;
          cmd.res      = ffba_pkg::RES_BADFREE;
          state_nxt    = S_DONE;
        end else if (flags.nxt_in) begin
          cmd.latch_cur = 1'b1;
          cmd.rd        = ffba_pkg::RD_NXT;
          state_nxt     = S_FNXT;
        end else begin
          cmd.wr       = ffba_pkg::WR_MERGE;
          cmd.res_load = 1'b1;
          cmd.res      = ffba_pkg::RES_OK;
          state_nxt    = S_DONE;
        end
      end
      S_FNXT: begin
        cmd.merging  = 1'b1;
        cmd.wr       = ffba_pkg::WR_MERGE;
        cmd.res_load = 1'b1;
        cmd.res      = ffba_pkg::RES_OK;
        state_nxt    = S_DONE;
      end
      // split: tail header first when the block is larger than the need, then the taken header
      S_TAKE: begin
        if (flags.cur_gt_need) begin
          cmd.wr = ffba_pkg::WR_TAIL;
        end
        state_nxt = S_TAKE2;
      end
      S_TAKE2: begin
        cmd.wr       = ffba_pkg::WR_TAKE;
        cmd.res_load = 1'b1;
        cmd.res      = ffba_pkg::RES_ALLOC_OK;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/core/first_fit_block_allocator_core.sv -----
// allocate and compact walk the headers from offset 0, one header read at a time, merging
//   free neighbors on the way; allocate then splits the taken block
// free walks the blocks before the target, then merges the freed block with a free neighbor
// throughput: one transaction at a time, set by the controller, which accepts only while idle
// reset and pool writes rewrite header 0 as one free block over the pool
// reset is synchronous active low and clears the controller and the output valid
module first_fit_block_allocator_core #(
  parameter int POOL_UNITS    = ffba_pkg::DEF_POOL_UNITS,
  parameter int GRANULE_BYTES = ffba_pkg::DEF_GRANULE_BYTES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // operation[1:0], request_bytes[15:2], block_offset[25:16], zero fill
  input  logic [ffba_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status[1:0], given_offset[11:2], largest_free[22:12], zero fill
  output logic [ffba_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ffba_pkg::CFG_W-1:0]        cfg_data
);

  ffba_pkg::ffba_cmd_t             cmd;
  ffba_pkg::ffba_flags_t           flags;
  logic [ffba_pkg::STATUS_W-1:0]   out_status;
  logic [ffba_pkg::OFFSET_W-1:0]   out_offset;
  logic [ffba_pkg::LARGEST_W-1:0]  out_largest;

  // control
  ffba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .flags      (flags),
    .cmd        (cmd)
  );

  // header store and walk datapath
  ffba_datapath #(
    .POOL_UNITS    (POOL_UNITS),
    .GRANULE_BYTES (GRANULE_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_op       (in_tdata[1:0]),
    .in_bytes    (in_tdata[15:2]),
    .in_offset   (in_tdata[25:16]),
    .cfg_value   (cfg_data),
    .flags       (flags),
    .out_status  (out_status),
    .out_offset  (out_offset),
    .out_largest (out_largest)
  );

  // result packing
  assign out_tdata = {1'b0, out_largest, out_offset, out_status};

endmodule

// ----- rtl/core/ffba_checker.sv -----
`include "first_fit_block_allocator_core_assert.svh"

module ffba_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [ffba_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ffba_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [ffba_pkg::CFG_W-1:0]      cfg_data
);

  // a stalled result holds
  `FFBA_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // one transaction at a time: busy right after an accept
  `FFBA_ASSERT_NXT(a_busy_after_in, in_tvalid && in_tready, !in_tready && !cfg_ready, "ready right after input accept")

  // pool write starts a header rewrite
  `FFBA_ASSERT_NXT(a_init_after_cfg, cfg_valid && cfg_ready, !in_tready && !cfg_ready, "ready right after pool write")

  // failed requests carry no offset and no size
  `FFBA_ASSERT_IMP(a_fail_fields, out_tvalid && (out_tdata[1:0] != ffba_pkg::ST_OK), out_tdata[22:2] == '0, "fields set on failed result")

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (.*);

// ----- sim/tb.sv -----
module tb;

  localparam int POOL_MAX     = ffba_pkg::DEF_POOL_UNITS;
  localparam int GRAIN        = ffba_pkg::DEF_GRANULE_BYTES;
  localparam int OP_W         = ffba_pkg::OP_W;
  localparam int BYTES_W      = ffba_pkg::BYTES_W;
  localparam int OFFSET_W     = ffba_pkg::OFFSET_W;
  localparam int STATUS_W     = ffba_pkg::STATUS_W;
  localparam int LARGEST_W    = ffba_pkg::LARGEST_W;
  localparam int CFG_W        = ffba_pkg::CFG_W;
  localparam int IN_DATA_W    = ffba_pkg::IN_DATA_W;
  localparam int OUT_DATA_W   = ffba_pkg::OUT_DATA_W;
  localparam int CYCLE_LIMIT  = 8_000_000;
  localparam int DRAIN_CYCLES = 2 * POOL_MAX + 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 70;
  localparam int NUM_PHASES   = 8;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // one reply of the allocator
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OFFSET_W-1:0]  given;
    logic [LARGEST_W-1:0] largest;
  } alloc_reply_t;

  // one row of the directed plan
  typedef struct packed {
    logic                is_cfg;
    logic [CFG_W-1:0]    cfg_val;
    logic [OP_W-1:0]     op;
    logic [BYTES_W-1:0]  nbytes;
    logic [OFFSET_W-1:0] boff;
    logic                typed;
    alloc_reply_t        want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data = '0;

  // shadow of the header store and the pool size
  int unsigned hdr_len [POOL_MAX];
  bit          hdr_used [POOL_MAX];
  int          pool_now;

  alloc_reply_t replies_due[$];
  plan_row_t    plan[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  bit           quiet = 1'b0;
  int           hold_token = 0;
  int           hold_seen = 0;
  int           hold_left = 0;

  first_fit_block_allocator_core #(
    .POOL_UNITS    (POOL_MAX),
    .GRANULE_BYTES (GRAIN)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // pool becomes one free block at offset 0
  function automatic void reinit_pool();
    for (int i = 0; i < POOL_MAX; i++) begin
      hdr_len[i]  = 0;
      hdr_used[i] = 1'b0;
    end
    hdr_len[0] = pool_now;
  endfunction

  // absorb following free blocks while the block at pos is below need
  function automatic void coalesce(int pos, int need);
    int nxt;
    while (int'(hdr_len[pos]) < need) begin
      nxt = pos + int'(hdr_len[pos]);
      if (nxt >= pool_now || hdr_used[nxt]) break;
      hdr_len[pos] = hdr_len[pos] + hdr_len[nxt];
    end
  endfunction

  // expected reply for one request, updating the shadow store
  function automatic alloc_reply_t run_allocator(logic [OP_W-1:0] op,
                                                 logic [BYTES_W-1:0] nb,
                                                 logic [OFFSET_W-1:0] bo);
    alloc_reply_t r;
    int need, pos, sz, nxt, tgt, best;
    bit done;
    r = '0;
    pos = 0;
    done = 1'b0;
    case (op)
      ffba_pkg::OP_ALLOC: begin
        need = (int'(nb) + GRAIN - 1) / GRAIN + 1;
        while (pos < pool_now) begin
          if (!hdr_used[pos]) begin
            coalesce(pos, need);
            sz = int'(hdr_len[pos]);
            if (sz >= need) begin
              if (sz > need) begin
                hdr_len[pos + need]  = sz - need;
                hdr_used[pos + need] = 1'b0;
              end
              hdr_len[pos]  = need;
              hdr_used[pos] = 1'b1;
              r.given = OFFSET_W'(pos);
              done = 1'b1;
              break;
            end
          end
          sz = int'(hdr_len[pos]);
          if (sz == 0) break;
          pos += sz;
        end
        if (!done) r.status = ffba_pkg::ST_NOFIT;
      end
      ffba_pkg::OP_FREE: begin
        tgt = int'(bo);
        while (pos < pool_now && pos < tgt) begin
          sz = int'(hdr_len[pos]);
          if (sz == 0) begin
            done = 1'b1;
            break;
          end
          pos += sz;
        end
        if (done || pos != tgt || pos >= pool_now || !hdr_used[pos]) begin
          r.status = ffba_pkg::ST_BADFREE;
        end else begin
          hdr_used[pos] = 1'b0;
          nxt = pos + int'(hdr_len[pos]);
          if (nxt < pool_now && !hdr_used[nxt]) hdr_len[pos] = hdr_len[pos] + hdr_len[nxt];
        end
      end
      ffba_pkg::OP_COMPACT: begin
        best = 0;
        while (pos < pool_now) begin
          if (!hdr_used[pos]) begin
            coalesce(pos, 1 << 30);
            if (int'(hdr_len[pos]) > best) best = int'(hdr_len[pos]);
          end
          sz = int'(hdr_len[pos]);
          if (sz == 0) break;
          pos += sz;
        end
        r.largest = LARGEST_W'(best);
      end
      default: ;
    endcase
    return r;
  endfunction

  // random allocated block start, or -1 when none
  function automatic int pick_live();
    int starts[$];
    int pos;
    pos = 0;
    while (pos < pool_now) begin
      if (hdr_used[pos]) starts.push_back(pos);
      if (hdr_len[pos] == 0) break;
      pos += int'(hdr_len[pos]);
    end
    if (starts.size() == 0) return -1;
    return starts[$urandom_range(starts.size() - 1)];
  endfunction

  function automatic void plan_cfg(int v);
    plan_row_t r;
    r = '0;
    r.is_cfg  = 1'b1;
    r.cfg_val = CFG_W'(v);
    plan.push_back(r);
  endfunction

  function automatic void plan_check(logic [OP_W-1:0] op, int nb, int bo,
                                     logic [STATUS_W-1:0] st, int go, int lg);
    plan_row_t r;
    r = '0;
    r.op           = op;
    r.nbytes       = BYTES_W'(nb);
    r.boff         = OFFSET_W'(bo);
    r.typed        = 1'b1;
    r.want.status  = st;
    r.want.given   = OFFSET_W'(go);
    r.want.largest = LARGEST_W'(lg);
    plan.push_back(r);
  endfunction

  function automatic void plan_run(logic [OP_W-1:0] op, int nb, int bo);
    plan_row_t r;
    r = '0;
    r.op     = op;
    r.nbytes = BYTES_W'(nb);
    r.boff   = OFFSET_W'(bo);
    plan.push_back(r);
  endfunction

  // offer one request, record its expected reply on acceptance
  task automatic offer(input logic [OP_W-1:0] op, input logic [BYTES_W-1:0] nb,
                       input logic [OFFSET_W-1:0] bo, input bit typed,
                       input alloc_reply_t want);
    alloc_reply_t calc;
    if (!quiet && $urandom_range(99) < 9) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, bo, nb, op};
    do @(posedge clk); while (!in_tready);
    calc = run_allocator(op, nb, bo);
    replies_due.push_back(typed ? want : calc);
  endtask

  // stop offering and wait for every pending reply
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // pool size write, clamped like the block does
  task automatic write_pool(input logic [CFG_W-1:0] v);
    int eff;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    eff = int'(v);
    if (eff < 2) eff = 2;
    if (eff > POOL_MAX) eff = POOL_MAX;
    pool_now = eff;
    reinit_pool();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= 9);
    end
  end

  // reply checker
  always @(posedge clk) begin
    alloc_reply_t want, seen;
    if (rst_n && out_tvalid && out_tready) begin
      seen.status  = out_tdata[1:0];
      seen.given   = out_tdata[11:2];
      seen.largest = out_tdata[22:12];
      if (replies_due.size() == 0) begin
        $error("reply with no request pending: status %0d given %0d largest %0d",
               seen.status, seen.given, seen.largest);
        mismatch_count++;
      end else begin
        want = replies_due.pop_front();
        if (seen.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, seen.status);
          mismatch_count++;
        end
        if (seen.given !== want.given) begin
          $error("given_offset: expected %0d, got %0d", want.given, seen.given);
          mismatch_count++;
        end
        if (seen.largest !== want.largest) begin
          $error("largest_free: expected %0d, got %0d", want.largest, seen.largest);
          mismatch_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int phase_pool [NUM_PHASES];
    int roll, span, live;
    logic [OP_W-1:0]     op;
    logic [BYTES_W-1:0]  nb;
    logic [OFFSET_W-1:0] bo;

    // directed plan, pool of 1024 after reset
    plan_check(ffba_pkg::OP_COMPACT, 0, 0, ffba_pkg::ST_OK, 0, 1024);
    plan_check(ffba_pkg::OP_ALLOC, 0, 0, ffba_pkg::ST_OK, 0, 0);
    plan_check(ffba_pkg::OP_ALLOC, 16383, 0, ffba_pkg::ST_NOFIT, 0, 0);
    plan_check(ffba_pkg::OP_ALLOC, 8192, 0, ffba_pkg::ST_NOFIT, 0, 0);
    plan_check(ffba_pkg::OP_FREE, 0, 1023, ffba_pkg::ST_BADFREE, 0, 0);
    plan_check(ffba_pkg::OP_FREE, 0, 5, ffba_pkg::ST_BADFREE, 0, 0);
    plan_check(ffba_pkg::OP_FREE, 0, 0, ffba_pkg::ST_OK, 0, 0);
    plan_check(ffba_pkg::OP_FREE, 0, 0, ffba_pkg::ST_BADFREE, 0, 0);
    plan_check(OP_UNUSED, 16383, 1023, ffba_pkg::ST_OK, 0, 0);
    plan_check(ffba_pkg::OP_ALLOC, 8184, 0, ffba_pkg::ST_OK, 0, 0);
    plan_check(ffba_pkg::OP_COMPACT, 0, 0, ffba_pkg::ST_OK, 0, 0);
    plan_check(ffba_pkg::OP_FREE, 0, 0, ffba_pkg::ST_OK, 0, 0);
    plan_run(ffba_pkg::OP_ALLOC, 1, 0);
    plan_run(ffba_pkg::OP_ALLOC, 8, 0);
    plan_run(ffba_pkg::OP_ALLOC, 9, 0);
    plan_run(ffba_pkg::OP_ALLOC, 100, 0);
    plan_run(ffba_pkg::OP_FREE, 0, 2);
    plan_run(ffba_pkg::OP_FREE, 0, 4);
    plan_run(ffba_pkg::OP_COMPACT, 0, 0);
    plan_run(ffba_pkg::OP_ALLOC, 24, 0);
    // out of range pool writes clamp at both ends
    plan_cfg(2047);
    plan_cfg(0);
    plan_check(ffba_pkg::OP_ALLOC, 0, 0, ffba_pkg::ST_OK, 0, 0);
    plan_check(ffba_pkg::OP_ALLOC, 0, 0, ffba_pkg::ST_OK, 1, 0);
    plan_check(ffba_pkg::OP_ALLOC, 0, 0, ffba_pkg::ST_NOFIT, 0, 0);
    plan_check(ffba_pkg::OP_FREE, 0, 1, ffba_pkg::ST_OK, 0, 0);
    plan_check(ffba_pkg::OP_COMPACT, 0, 0, ffba_pkg::ST_OK, 0, 1);

    phase_pool = '{1024, 48, 1, 300, 2047, 0, 16, 700};
    phase_pool[5] = $urandom_range(2047);

    pool_now = POOL_MAX;
    reinit_pool();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_pool(plan[i].cfg_val);
      end else begin
        offer(plan[i].op, plan[i].nbytes, plan[i].boff, plan[i].typed, plan[i].want);
      end
    end

    // random phases, one pool setting each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      write_pool(CFG_W'(phase_pool[ph]));
      quiet = (ph == 4);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 2 && k == 30) drain();
        if (ph == 3 && k == 20) hold_token++;
        span = (pool_now > 8) ? pool_now / 8 : 1;
        roll = $urandom_range(99);
        nb = BYTES_W'($urandom);
        bo = OFFSET_W'($urandom);
        if (roll < 45) begin
          op = ffba_pkg::OP_ALLOC;
          if ($urandom_range(9) != 0) nb = BYTES_W'($urandom_range(0, GRAIN * span));
        end else if (roll < 78) begin
          live = pick_live();
          if (live >= 0) begin
            op = ffba_pkg::OP_FREE;
            bo = OFFSET_W'(live);
          end else begin
            op = ffba_pkg::OP_ALLOC;
            nb = BYTES_W'($urandom_range(0, GRAIN * span));
          end
        end else if (roll < 86) begin
          op = ffba_pkg::OP_FREE;
        end else if (roll < 94) begin
          op = ffba_pkg::OP_COMPACT;
        end else begin
          op = OP_UNUSED;
        end
        offer(op, nb, bo, 1'b0, '0);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/ffba_pkg.sv
rtl/core/ffba_datapath.sv
rtl/core/ffba_ctrl.sv
rtl/core/first_fit_block_allocator_core.sv
rtl/core/ffba_checker.sv
sim/tb.sv
